>>> rtl/dpm_pkg.sv
// Package for the truncating binary64 multiplier.
// Field widths, exponent constants and shared types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dpm_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned FRAC_W   = 52;
  localparam int unsigned EXP_W    = 11;
  localparam int unsigned SIG_W    = FRAC_W + 1;           // with hidden one
  localparam int unsigned PROD_W   = 2 * SIG_W;            // 106
  localparam int unsigned SPLIT_LO = 27;                   // low slice of a significand
  localparam int unsigned SPLIT_HI = SIG_W - SPLIT_LO;     // high slice
  localparam int unsigned EXPS_W   = EXP_W + 2;            // signed biased exponent

  localparam logic [EXPS_W-1:0] EXP_BIAS       = EXPS_W'(1023);
  localparam logic [EXPS_W-1:0] EXP_MAX_NORMAL = EXPS_W'(2046);

  typedef logic [SIG_W-1:0]  sig_t;
  typedef logic [PROD_W-1:0] prod_t;

endpackage : dpm_pkg
`default_nettype wire

>>> rtl/dpm_mul53.sv
// Pipelined 53 x 53 bit unsigned significand multiplier, two register stages.
// Depends on dpm_pkg for widths and types.
`timescale 1ns / 1ps
`default_nettype none
module dpm_mul53 (
  input  wire             clk,
  input  wire             en,      // pipeline advance
  input  dpm_pkg::sig_t   sig_a,
  input  dpm_pkg::sig_t   sig_b,
  output dpm_pkg::prod_t  prod     // registered, after the partial-product and product registers
);
  import dpm_pkg::*;

  logic [2*SPLIT_LO-1:0]        pp_ll_r, pp_ll_nxt;
  logic [SPLIT_LO+SPLIT_HI-1:0] pp_lh_r, pp_lh_nxt;
  logic [SPLIT_LO+SPLIT_HI-1:0] pp_hl_r, pp_hl_nxt;
  logic [2*SPLIT_HI-1:0]        pp_hh_r, pp_hh_nxt;
  prod_t                        prod_r, prod_nxt;

  // Four partial products, each no wider than 27 x 27 bits.
  always_comb begin
    pp_ll_nxt = (2*SPLIT_LO)'(sig_a[SPLIT_LO-1:0]) * (2*SPLIT_LO)'(sig_b[SPLIT_LO-1:0]);
    pp_lh_nxt = (SPLIT_LO+SPLIT_HI)'(sig_a[SPLIT_LO-1:0]) *
                (SPLIT_LO+SPLIT_HI)'(sig_b[SIG_W-1:SPLIT_LO]);
    pp_hl_nxt = (SPLIT_LO+SPLIT_HI)'(sig_a[SIG_W-1:SPLIT_LO]) *
                (SPLIT_LO+SPLIT_HI)'(sig_b[SPLIT_LO-1:0]);
    pp_hh_nxt = (2*SPLIT_HI)'(sig_a[SIG_W-1:SPLIT_LO]) * (2*SPLIT_HI)'(sig_b[SIG_W-1:SPLIT_LO]);
  end

  // Align and sum the partial products into the exact product.
  always_comb begin
    prod_nxt = (PROD_W'(pp_hh_r) << (2*SPLIT_LO))
             + ((PROD_W'(pp_lh_r) + PROD_W'(pp_hl_r)) << SPLIT_LO)
             + PROD_W'(pp_ll_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
      prod_r  <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule : dpm_mul53
`default_nettype wire

>>> rtl/double_precision_multiplier.sv
// Truncating binary64 multiplier: four register stages (input register, partial products,
// product sum, normalize/output), which each input transaction passes through in that order.
// Throughput is one transaction per cycle; the whole pipeline stalls together
// only while the output register holds a result that is not taken.
// Reset (rst_n low, synchronous) clears all stage valid bits and holds in_tready low;
// data is not reset. Depends on dpm_pkg and dpm_mul53.
`timescale 1ns / 1ps
`default_nettype none
module double_precision_multiplier (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [127:0] in_tdata,   // [63:0] operand_a, [127:64] operand_b
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // [63:0] product
  output logic        out_tuser   // [0] exponent_out_of_range
);
  import dpm_pkg::*;

  logic              adv;
  logic [2:0]        vld_r, vld_nxt;     // stages 1..3
  logic              out_vld_r, out_vld_nxt;

  // Stage 1: unpacked operands.
  sig_t              sig_a_r, sig_b_r;
  logic              sign1_r;
  logic [EXP_W:0]    esum1_r;
  // Stages 2 and 3: sign and exponent sum travel beside the multiplier.
  logic              sign2_r, sign3_r;
  logic [EXP_W:0]    esum2_r, esum3_r;
  prod_t             prod;

  logic [63:0]       res_r, res_nxt;
  logic              oor_r, oor_nxt;
  logic              norm;
  logic [EXPS_W-1:0] exp_s;
  logic [FRAC_W-1:0] frac;

  // The pipeline moves whenever the output register is free or being drained.
  // No input is taken while reset is held.
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = rst_n && adv;

  assign vld_nxt     = {vld_r[1:0], in_tvalid};
  assign out_vld_nxt = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input register (hidden ones attached, signs XORed, exponent fields summed) and stage 2 and 3 sign/exponent copies.
  always_ff @(posedge clk) begin
    if (adv) begin
      sig_a_r <= {1'b1, in_tdata[FRAC_W-1:0]};
      sig_b_r <= {1'b1, in_tdata[64+FRAC_W-1:64]};
      sign1_r <= in_tdata[63] ^ in_tdata[127];
      esum1_r <= (EXP_W+1)'(in_tdata[62:52]) + (EXP_W+1)'(in_tdata[126:116]);
      sign2_r <= sign1_r;
      esum2_r <= esum1_r;
      sign3_r <= sign2_r;
      esum3_r <= esum2_r;
    end
  end

  dpm_mul53 u_mul (
    .clk   (clk),
    .en    (adv),
    .sig_a (sig_a_r),
    .sig_b (sig_b_r),
    .prod  (prod)
  );

  // Normalize by one bit when the top product bit is set, then truncate and flag an out-of-range exponent.
  always_comb begin
    norm  = prod[PROD_W-1];
    frac  = norm ? prod[PROD_W-2 -: FRAC_W] : prod[PROD_W-3 -: FRAC_W];
    exp_s = EXPS_W'(esum3_r) - EXP_BIAS + EXPS_W'(norm);
    oor_nxt = exp_s[EXPS_W-1] || (exp_s == '0) || ($signed(exp_s) > $signed(EXP_MAX_NORMAL));
    res_nxt = {sign3_r, exp_s[EXP_W-1:0], frac};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      oor_r <= oor_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;
  assign out_tuser  = oor_r;

endmodule : double_precision_multiplier
`default_nettype wire

>>> rtl/dpm_checker.sv
// Port-level checker for the truncating binary64 multiplier, with its bind.
// Depends only on the ports of double_precision_multiplier.
`timescale 1ns / 1ps
`default_nettype none
module dpm_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [63:0]  out_tdata,
  input wire         out_tuser
);

  // A stalled result keeps its transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A held result blocks new input.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // With the sink ready while it moves through the stages, an accepted transaction reaches the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing after pipeline latency");

  // An in-range flag-free result has a normal exponent field.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[62:52] != 11'h000 && out_tdata[62:52] != 11'h7FF)
    else $error("exponent field inconsistent with range flag");

endmodule : dpm_checker

bind double_precision_multiplier dpm_checker u_dpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
